@@ rtl/two_level_bitmap_set_pred_succ_assert.svh @@
// Assertion macros used by the checked module.
`ifndef TWO_LEVEL_BITMAP_SET_PRED_SUCC_ASSERT_SVH
`define TWO_LEVEL_BITMAP_SET_PRED_SUCC_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define TLBS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlbs assertion failed");

// Next-cycle implication, disabled while in reset.
`define TLBS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlbs assertion failed");

`endif

@@ rtl/tlbs_pkg.sv @@
package tlbs_pkg;

   // Fixed field widths of the stream payload
   localparam int KEY_W      = 10;
   localparam int KIND_W     = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 1;

   // Default geometry of the set
   localparam int DEF_UNIVERSE = 1024;
   localparam int DEF_ROW_BITS = 32;

   // Item kinds carried in req_tuser
   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_PRED   = 2'd1,
      KIND_SUCC   = 2'd2
   } kind_type;

endpackage

@@ rtl/tlbs_ram.sv @@
module tlbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tlbs_find.sv @@
module tlbs_find #(
   parameter int W = 32
) (
   input  logic [W-1:0]         word,
   input  logic [W-1:0]         mask,
   input  logic                 find_high,
   output logic                 found,
   output logic [$clog2(W)-1:0] pos
);

   localparam int PW = $clog2(W);

   logic [W-1:0] hits;

   assign hits  = word & mask;
   assign found = |hits;

   // Priority-encode the highest or the lowest set bit
   always_comb begin
      pos = '0;
      if (find_high) begin
         for (int j = 0; j < W; j++) begin
            if (hits[j]) pos = PW'(j);
         end
      end else begin
         for (int j = W - 1; j >= 0; j--) begin
            if (hits[j]) pos = PW'(j);
         end
      end
   end

endmodule

@@ rtl/two_level_bitmap_set_pred_succ.sv @@
// Two-level bitmap integer set with insert, predecessor and successor.
// Input beats on req_*: req_tuser is the kind (insert, predecessor, successor),
// req_tdata[9:0] the key. Each accepted beat gives exactly one rsp_* beat with
// the answer, a found flag in rsp_tuser, and the current max, min and
// non-empty flag. Keys sit in rows of ROW_BITS bits (ROW_BITS a power
// of two) in a RAM; a summary bit per row marks rows that hold members.
// One bit-finder is shared by every search step under a small sequencer; the
// RAM read port sets the pace (one row per cycle, read data registered).
// Path from accept to rsp_tvalid: kind 3 and an out-of-range key that needs
// no search go straight to S_OUT; insert passes S_INS, and a query answered in
// its own row passes S_ROW, before S_OUT; any other query goes from S_ROW to
// S_SUM, which scans G summary words (from 1 up to ceil(rows / ROW_BITS)),
// then to S_ROW2 when a member is found, and then to S_OUT.
// The block takes one item at a time: req_tready is high only when idle, so
// the next item is accepted only once the last one has left S_OUT.
// A result waits in an output register; a new item is accepted meanwhile, and
// its own result is held back until rsp_tready takes the waiting one.
// Synchronous reset empties the set at once (summary bits act as row valids).
`include "two_level_bitmap_set_pred_succ_assert.svh"

module two_level_bitmap_set_pred_succ #(
   parameter int UNIVERSE = tlbs_pkg::DEF_UNIVERSE,
   parameter int ROW_BITS = tlbs_pkg::DEF_ROW_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tlbs_pkg::REQ_DATA_W-1:0] req_tdata,  // [9:0] key
   input  logic [tlbs_pkg::KIND_W-1:0]     req_tuser,  // [1:0] kind
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [9:0] answer_key, [19:10] max_key, [29:20] min_key, [30] nonempty
   output logic [tlbs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [tlbs_pkg::RSP_USER_W-1:0] rsp_tuser   // [0] found
);

   import tlbs_pkg::*;

   localparam int CB     = $clog2(ROW_BITS);
   localparam int NC     = (UNIVERSE + ROW_BITS - 1) / ROW_BITS;
   localparam int CIW    = (NC > 1) ? $clog2(NC) : 1;
   localparam int NG     = (NC + ROW_BITS - 1) / ROW_BITS;
   localparam int GW     = (NG > 1) ? $clog2(NG) : 1;
   localparam int SPW    = NG * ROW_BITS;
   localparam int UB     = $clog2(UNIVERSE) + 1;
   localparam int CMP_W  = (UB > KEY_W) ? UB : KEY_W;
   localparam int RSP_PAD = RSP_DATA_W - 3 * KEY_W - 1;
   localparam logic [CIW-1:0] LAST_C = CIW'(NC - 1);
   localparam logic [GW-1:0]  LAST_G = GW'(NG - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROW,
      S_INS,
      S_SUM,
      S_ROW2,
      S_OUT
   } state_type;

   // Control and set state
   state_type         state_ff, state_in;
   logic [NC-1:0]     summary_ff, summary_in;
   logic [KEY_W-1:0]  max_ff, max_in, min_ff, min_in;
   logic              nonempty_ff, nonempty_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              first_ff, first_in;

   // Per-item payload
   kind_type          kind_ff, kind_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [CIW-1:0]    c_ff, c_in;
   logic [CB-1:0]     off_ff, off_in;
   logic              oor_ff, oor_in;
   logic [GW-1:0]     g_ff, g_in;
   logic [KEY_W-1:0]  ans_ff, ans_in;
   logic              hit_ff, hit_in;

   // Result register
   logic [KEY_W-1:0]  rsp_ans_ff, rsp_ans_in, rsp_max_ff, rsp_max_in;
   logic [KEY_W-1:0]  rsp_min_ff, rsp_min_in;
   logic              rsp_hit_ff, rsp_hit_in, rsp_ne_ff, rsp_ne_in;

   // Datapath
   logic [KEY_W-1:0]    req_key;
   kind_type            req_kind;
   logic                req_oor;
   logic [CIW-1:0]      req_c;
   logic [CIW-1:0]      rd_addr;
   logic [ROW_BITS-1:0] rd_data, row_word, wr_data;
   logic [ROW_BITS-1:0] below_m, above_m, gbelow_m, gabove_m;
   logic [CB-1:0]       within_c;
   logic [SPW-1:0]      sum_pad;
   logic [ROW_BITS-1:0] sum_word;
   logic [ROW_BITS-1:0] f_word, f_mask;
   logic                f_high, f_found;
   logic [CB-1:0]       f_pos;
   logic [CIW-1:0]      sum_c;
   logic                is_pred;

   // Decode the incoming beat
   assign req_key  = req_tdata[KEY_W-1:0];
   assign req_kind = kind_type'(req_tuser);
   assign req_oor  = (CMP_W'(req_key) >= CMP_W'(UNIVERSE));
   assign req_c    = CIW'(req_key >> CB);
   assign req_tready = (state_ff == S_IDLE);

   // Rows whose summary bit is clear read as empty
   assign row_word = summary_ff[c_ff] ? rd_data : '0;
   assign wr_data  = row_word | (ROW_BITS'(1) << off_ff);
   assign within_c = CB'(c_ff);
   assign sum_pad  = SPW'(summary_ff);
   assign sum_word = sum_pad[g_ff * ROW_BITS +: ROW_BITS];
   assign sum_c    = CIW'({g_ff, f_pos});
   assign is_pred  = (kind_ff == KIND_PRED);

   // Position masks inside a row and inside a summary word
   always_comb begin
      for (int j = 0; j < ROW_BITS; j++) begin
         below_m[j]  = oor_ff || (CB'(j) < off_ff);
         above_m[j]  = (CB'(j) > off_ff);
         gbelow_m[j] = (CB'(j) < within_c);
         gabove_m[j] = (CB'(j) > within_c);
      end
   end

   // Feed the shared bit-finder
   always_comb begin
      f_word = '0;
      f_mask = '0;
      f_high = is_pred;
      unique case (state_ff)
         S_ROW: begin
            f_word = row_word;
            f_mask = is_pred ? below_m : above_m;
         end
         S_SUM: begin
            f_word = sum_word;
            if (first_ff) f_mask = is_pred ? gbelow_m : gabove_m;
            else          f_mask = '1;
         end
         S_ROW2: begin
            f_word = row_word;
            f_mask = '1;
         end
         default: begin
            f_word = '0;
         end
      endcase
   end

   tlbs_find #(
      .W (ROW_BITS)
   ) u_find (
      .word      (f_word),
      .mask      (f_mask),
      .find_high (f_high),
      .found     (f_found),
      .pos       (f_pos)
   );

   // Row read address: new key when idle, found cluster during the scan
   assign rd_addr = (state_ff == S_SUM) ? sum_c
                  : ((req_oor && req_kind == KIND_PRED) ? LAST_C : req_c);

   tlbs_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (NC)
   ) u_rows (
      .clock   (clock),
      .wr_en   (state_ff == S_INS),
      .wr_addr (c_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      summary_in   = summary_ff;
      max_in       = max_ff;
      min_in       = min_ff;
      nonempty_in  = nonempty_ff;
      rsp_valid_in = rsp_valid_ff;
      first_in     = first_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      c_in         = c_ff;
      off_in       = off_ff;
      oor_in       = oor_ff;
      g_in         = g_ff;
      ans_in       = ans_ff;
      hit_in       = hit_ff;
      rsp_ans_in   = rsp_ans_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_ne_in    = rsp_ne_ff;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in = req_kind;
               key_in  = req_key;
               off_in  = CB'(req_key);
               oor_in  = req_oor;
               c_in    = (req_oor && req_kind == KIND_PRED) ? LAST_C : req_c;
               ans_in  = '0;
               hit_in  = 1'b0;
               unique case (req_kind)
                  KIND_INSERT: state_in = req_oor ? S_OUT : S_INS;
                  KIND_PRED:   state_in = S_ROW;
                  KIND_SUCC:   state_in = req_oor ? S_OUT : S_ROW;
                  default:     state_in = S_OUT;
               endcase
            end
         end
         S_ROW: begin
            if (f_found) begin
               ans_in   = KEY_W'({c_ff, f_pos});
               hit_in   = 1'b1;
               state_in = S_OUT;
            end else begin
               g_in     = GW'(c_ff >> CB);
               first_in = 1'b1;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            first_in = 1'b0;
            if (f_found) begin
               c_in     = sum_c;
               state_in = S_ROW2;
            end else if (is_pred && g_ff != '0) begin
               g_in = g_ff - GW'(1);
            end else if (!is_pred && g_ff != LAST_G) begin
               g_in = g_ff + GW'(1);
            end else begin
               state_in = S_OUT;
            end
         end
         S_ROW2: begin
            ans_in   = f_found ? KEY_W'({c_ff, f_pos}) : '0;
            hit_in   = f_found;
            state_in = S_OUT;
         end
         S_INS: begin
            summary_in[c_ff] = 1'b1;
            nonempty_in      = 1'b1;
            if (!nonempty_ff) begin
               max_in = key_ff;
               min_in = key_ff;
            end else begin
               if (key_ff > max_ff) max_in = key_ff;
               if (key_ff < min_ff) min_in = key_ff;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ans_in   = ans_ff;
               rsp_hit_in   = hit_ff;
               rsp_max_in   = max_ff;
               rsp_min_in   = min_ff;
               rsp_ne_in    = nonempty_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, set contents and registered outputs
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      key_ff     <= key_in;
      c_ff       <= c_in;
      off_ff     <= off_in;
      oor_ff     <= oor_in;
      g_ff       <= g_in;
      ans_ff     <= ans_in;
      hit_ff     <= hit_in;
      rsp_ans_ff <= rsp_ans_in;
      rsp_max_ff <= rsp_max_in;
      rsp_min_ff <= rsp_min_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_ne_ff  <= rsp_ne_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         summary_ff   <= '0;
         max_ff       <= '0;
         min_ff       <= '0;
         nonempty_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         summary_ff   <= summary_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         nonempty_ff  <= nonempty_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_ne_ff, rsp_min_ff, rsp_max_ff, rsp_ans_ff};
   assign rsp_tuser  = rsp_hit_ff;

   // Checks
   `TLBS_ASSERT_NEXT(a_take_one, clock, reset, req_tvalid && req_tready, !req_tready)
   `TLBS_ASSERT_IMP(a_found_nonempty, clock, reset, rsp_valid_ff && rsp_hit_ff, rsp_ne_ff)
   `TLBS_ASSERT_IMP(a_min_le_max, clock, reset, rsp_valid_ff && rsp_ne_ff, rsp_min_ff <= rsp_max_ff)
   `TLBS_ASSERT_IMP(a_ins_marks, clock, reset, state_ff == S_OUT && $past(state_ff) == S_INS, nonempty_ff && summary_ff[c_ff])

endmodule
